// ===== rtl/erot_pkg.sv =====
// ----------------------------------------------------------------------------
// erot_pkg
// Shared constants and helpers for the Euler XYZ point rotation core.
// ----------------------------------------------------------------------------
package erot_pkg;

  // Default field widths.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Phase fed to the CORDIC: 65536 equals one full turn.
  localparam int PHASE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  // Width of the CORDIC x/y datapath (Q1.30 plus growth) and of the angle residue.
  localparam int CORDIC_WIDTH = 34;
  localparam int RES_WIDTH    = 18;
  // Width of cosine and sine in Q1.16.
  localparam int CS_WIDTH     = 18;
  // Start value of x: CORDIC gain compensation in Q1.30.
  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
  // Extra bits carried by coordinates between axis stages.
  localparam int COORD_GUARD  = 4;
  // Latencies of the sub-units.
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int AXIS_LAT     = 2;

  // Arctangent table in phase units.
  function automatic logic [RES_WIDTH-1:0] atan_step(input int idx);
    logic [RES_WIDTH-1:0] val;
    case (idx)
      0:       val = RES_WIDTH'(8192);
      1:       val = RES_WIDTH'(4836);
      2:       val = RES_WIDTH'(2555);
      3:       val = RES_WIDTH'(1297);
      4:       val = RES_WIDTH'(651);
      5:       val = RES_WIDTH'(326);
      6:       val = RES_WIDTH'(163);
      7:       val = RES_WIDTH'(81);
      8:       val = RES_WIDTH'(41);
      9:       val = RES_WIDTH'(20);
      10:      val = RES_WIDTH'(10);
      11:      val = RES_WIDTH'(5);
      12:      val = RES_WIDTH'(3);
      13:      val = RES_WIDTH'(1);
      14:      val = RES_WIDTH'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/erot_cordic.sv =====
// ----------------------------------------------------------------------------
// erot_cordic
// Pipelined CORDIC: one rotation step per register stage, giving cos and sin.
// ----------------------------------------------------------------------------
module erot_cordic
  import erot_pkg::*;
(
  input  logic                          clk,
  input  logic                          ce,
  input  logic [PHASE_WIDTH-1:0]        phase,
  output logic signed [CS_WIDTH-1:0]    cos_val,
  output logic signed [CS_WIDTH-1:0]    sin_val
);

  logic signed [CORDIC_WIDTH-1:0] xs  [0:CORDIC_STEPS];
  logic signed [CORDIC_WIDTH-1:0] ys  [0:CORDIC_STEPS];
  logic signed [RES_WIDTH-1:0]    zs  [0:CORDIC_STEPS];
  logic                           neg [0:CORDIC_STEPS];

  logic signed [RES_WIDTH-1:0] z_fold;
  logic                        mid;
  logic signed [CORDIC_WIDTH-1:0] x_rnd;
  logic signed [CORDIC_WIDTH-1:0] y_rnd;
  logic signed [CS_WIDTH-1:0]     c_cut;
  logic signed [CS_WIDTH-1:0]     s_cut;

  // Quadrant fold: the two middle quadrants move by half a turn and flip sign.
  assign mid = phase[PHASE_WIDTH-1] ^ phase[PHASE_WIDTH-2];
  always_comb begin
    if (mid) begin
      z_fold = RES_WIDTH'($signed({~phase[PHASE_WIDTH-1], phase[PHASE_WIDTH-2:0]}));
    end else begin
      z_fold = RES_WIDTH'($signed(phase));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xs[0]  <= CORDIC_GAIN;
      ys[0]  <= '0;
      zs[0]  <= z_fold;
      neg[0] <= mid;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_WIDTH-1:0] xsh;
    logic signed [CORDIC_WIDTH-1:0] ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (ce) begin
        neg[i+1] <= neg[i];
        if (!zs[i][RES_WIDTH-1]) begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - $signed(atan_step(i));
        end else begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + $signed(atan_step(i));
        end
      end
    end
  end

  // Round to Q1.16 and undo the fold.
  assign x_rnd = (xs[CORDIC_STEPS] + CORDIC_WIDTH'(8192)) >>> 14;
  assign y_rnd = (ys[CORDIC_STEPS] + CORDIC_WIDTH'(8192)) >>> 14;
  assign c_cut = x_rnd[CS_WIDTH-1:0];
  assign s_cut = y_rnd[CS_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_val <= neg[CORDIC_STEPS] ? -c_cut : c_cut;
      sin_val <= neg[CORDIC_STEPS] ? -s_cut : s_cut;
    end
  end

endmodule

// ===== rtl/erot_axis.sv =====
// ----------------------------------------------------------------------------
// erot_axis
// Plane rotation of (u, v) by one angle: products, then rounded sums.
// ----------------------------------------------------------------------------
module erot_axis
  import erot_pkg::*;
#(
  parameter int IW = COORD_WIDTH_DEF + COORD_GUARD
) (
  input  logic                       clk,
  input  logic                       ce,
  input  logic signed [IW-1:0]       u,
  input  logic signed [IW-1:0]       v,
  input  logic signed [IW-1:0]       w,
  input  logic signed [CS_WIDTH-1:0] cos_val,
  input  logic signed [CS_WIDTH-1:0] sin_val,
  output logic signed [IW-1:0]       a,
  output logic signed [IW-1:0]       b,
  output logic signed [IW-1:0]       w_out
);

  localparam int PW = IW + CS_WIDTH;

  logic signed [PW-1:0] cu;
  logic signed [PW-1:0] sv;
  logic signed [PW-1:0] su;
  logic signed [PW-1:0] cv;
  logic signed [IW-1:0] w_d;
  logic signed [PW:0]   sum_a;
  logic signed [PW:0]   sum_b;

  // Stage 1: the four products.
  always_ff @(posedge clk) begin
    if (ce) begin
      cu  <= PW'(u) * PW'(cos_val);
      sv  <= PW'(v) * PW'(sin_val);
      su  <= PW'(u) * PW'(sin_val);
      cv  <= PW'(v) * PW'(cos_val);
      w_d <= w;
    end
  end

  // Stage 2: a = c*u - s*v, b = s*u + c*v, rounded half up to the coordinate LSB.
  assign sum_a = ((PW+1)'(cu) - (PW+1)'(sv) + (PW+1)'(32768)) >>> 16;
  assign sum_b = ((PW+1)'(su) + (PW+1)'(cv) + (PW+1)'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (ce) begin
      a     <= sum_a[IW-1:0];
      b     <= sum_b[IW-1:0];
      w_out <= w_d;
    end
  end

endmodule

// ===== rtl/euler_xyz_point_rotation_core.sv =====
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation_core
// Rotates a 3D point about X, then Y, then Z (result Rz*Ry*Rx*p).
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on the s_axis group, one point and three binary
//   angles each; results leave on the m_axis group, one point per input.
//   The block is a single stalling pipeline: three CORDIC units (one step per
//   stage) produce cos and sin of all angles in parallel, then three axis
//   stages (products, then rounded sums) rotate the point, and a final
//   register saturates to the coordinate range.
//   Throughput is one transaction per cycle while the output is not stalled;
//   the depth is set by the 16-step CORDIC pipeline.
//   When m_axis_tready is low while a result is waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_xyz_point_rotation_core
  import erot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int IN_BITS   = 3 * COORD_WIDTH + 3 * ANGLE_WIDTH,
  localparam int IN_BYTES  = (IN_BITS + 7) / 8,
  localparam int OUT_BITS  = 3 * COORD_WIDTH,
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0: in_x, in_y, in_z, angle_x, angle_y, angle_z, zero pad.
  input  logic [8*IN_BYTES-1:0]    s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from bit 0: out_x, out_y, out_z, zero pad.
  output logic [8*OUT_BYTES-1:0]   m_axis_tdata
);

  localparam int IW  = COORD_WIDTH + COORD_GUARD;
  localparam int LAT = CORDIC_LAT + 3 * AXIS_LAT + 1;
  localparam logic signed [IW-1:0] SAT_MAX = IW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [IW-1:0] SAT_MIN = IW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  logic ce;
  logic valid [0:LAT-1];

  logic [ANGLE_WIDTH-1:0] ang [0:2];
  logic [PHASE_WIDTH-1:0] phase [0:2];
  logic signed [CS_WIDTH-1:0] cs_c [0:2];
  logic signed [CS_WIDTH-1:0] cs_s [0:2];

  logic signed [IW-1:0] dx [0:CORDIC_LAT-1];
  logic signed [IW-1:0] dy [0:CORDIC_LAT-1];
  logic signed [IW-1:0] dz [0:CORDIC_LAT-1];

  // Sine and cosine of Y held until the Y axis stage, of Z until the Z axis stage.
  logic signed [CS_WIDTH-1:0] cy_d [0:AXIS_LAT-1];
  logic signed [CS_WIDTH-1:0] sy_d [0:AXIS_LAT-1];
  logic signed [CS_WIDTH-1:0] cz_d [0:2*AXIS_LAT-1];
  logic signed [CS_WIDTH-1:0] sz_d [0:2*AXIS_LAT-1];

  logic signed [IW-1:0] x1_y, x1_z, x1_x;
  logic signed [IW-1:0] y1_z, y1_x, y1_y;
  logic signed [IW-1:0] z1_x, z1_y, z1_z;
  logic [COORD_WIDTH-1:0] out_x, out_y, out_z;

  // The pipeline advances unless a finished result is stalled.
  assign ce            = !valid[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (ce) begin
      valid[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) begin
        valid[i] <= valid[i-1];
      end
    end
  end

  // Angles to 16-bit phase.
  for (genvar k = 0; k < 3; k++) begin : g_ang
    assign ang[k] = s_axis_tdata[3*COORD_WIDTH + k*ANGLE_WIDTH +: ANGLE_WIDTH];
    if (ANGLE_WIDTH < PHASE_WIDTH) begin : g_lo
      assign phase[k] = {ang[k], {(PHASE_WIDTH-ANGLE_WIDTH){1'b0}}};
    end else begin : g_hi
      assign phase[k] = ang[k][ANGLE_WIDTH-1 -: PHASE_WIDTH];
    end
    erot_cordic u_cordic (
      .clk     (clk),
      .ce      (ce),
      .phase   (phase[k]),
      .cos_val (cs_c[k]),
      .sin_val (cs_s[k])
    );
  end

  // Coordinates travel alongside the CORDIC pipeline.
  always_ff @(posedge clk) begin
    if (ce) begin
      dx[0] <= IW'($signed(s_axis_tdata[0 +: COORD_WIDTH]));
      dy[0] <= IW'($signed(s_axis_tdata[COORD_WIDTH +: COORD_WIDTH]));
      dz[0] <= IW'($signed(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
      for (int i = 1; i < CORDIC_LAT; i++) begin
        dx[i] <= dx[i-1];
        dy[i] <= dy[i-1];
        dz[i] <= dz[i-1];
      end
    end
  end

  // Align the later angles with their axis stage.
  always_ff @(posedge clk) begin
    if (ce) begin
      cy_d[0] <= cs_c[1];
      sy_d[0] <= cs_s[1];
      for (int i = 1; i < AXIS_LAT; i++) begin
        cy_d[i] <= cy_d[i-1];
        sy_d[i] <= sy_d[i-1];
      end
      cz_d[0] <= cs_c[2];
      sz_d[0] <= cs_s[2];
      for (int i = 1; i < 2*AXIS_LAT; i++) begin
        cz_d[i] <= cz_d[i-1];
        sz_d[i] <= sz_d[i-1];
      end
    end
  end

  // About X: (y, z) rotate, x passes.
  erot_axis #(.IW(IW)) u_axis_x (
    .clk(clk), .ce(ce),
    .u(dy[CORDIC_LAT-1]), .v(dz[CORDIC_LAT-1]), .w(dx[CORDIC_LAT-1]),
    .cos_val(cs_c[0]), .sin_val(cs_s[0]),
    .a(x1_y), .b(x1_z), .w_out(x1_x)
  );

  // About Y: (z, x) rotate, y passes.
  erot_axis #(.IW(IW)) u_axis_y (
    .clk(clk), .ce(ce),
    .u(x1_z), .v(x1_x), .w(x1_y),
    .cos_val(cy_d[AXIS_LAT-1]), .sin_val(sy_d[AXIS_LAT-1]),
    .a(y1_z), .b(y1_x), .w_out(y1_y)
  );

  // About Z: (x, y) rotate, z passes.
  erot_axis #(.IW(IW)) u_axis_z (
    .clk(clk), .ce(ce),
    .u(y1_x), .v(y1_y), .w(y1_z),
    .cos_val(cz_d[2*AXIS_LAT-1]), .sin_val(sz_d[2*AXIS_LAT-1]),
    .a(z1_x), .b(z1_y), .w_out(z1_z)
  );

  // Saturate into the output register.
  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [IW-1:0] val);
    logic signed [IW-1:0] lim;
    if (val > SAT_MAX) begin
      lim = SAT_MAX;
    end else if (val < SAT_MIN) begin
      lim = SAT_MIN;
    end else begin
      lim = val;
    end
    return lim[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ce) begin
      out_x <= sat(z1_x);
      out_y <= sat(z1_y);
      out_z <= sat(z1_z);
    end
  end

  assign m_axis_tdata = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, out_z, out_y, out_x};

endmodule

// ===== test/erot_checker.sv =====
// ----------------------------------------------------------------------------
// erot_checker
// Watches both stream channels of the rotation core, computes the rotated
// point for every accepted input transaction and compares each output
// transaction field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module erot_checker
  import erot_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } point_t;

  point_t rotated_q[$];

  // Sine and cosine of a binary angle in Q1.16, via a 16-step CORDIC.
  function automatic void angle_sincos(input logic [15:0] ang,
                                       output longint c, output longint s);
    longint x, y, z, nx;
    bit     flip;
    int     i;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang >= 16384 && ang < 49152) begin
      z = longint'(ang) - 32768;
      flip = 1;
    end else if (ang < 16384) begin
      z = longint'(ang);
    end else begin
      z = longint'(ang) - 65536;
    end
    for (i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_step(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_step(i));
      end
      x = nx;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Rotation Rz*Ry*Rx*p with round-half-up after every axis stage.
  function automatic point_t rotate_point(input logic [95:0] d);
    longint x, y, z, c, s, a, b;
    point_t r;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    angle_sincos(d[63:48], c, s);
    a = (c * y - s * z + 32768) >>> 16;
    b = (s * y + c * z + 32768) >>> 16;
    y = a;
    z = b;
    angle_sincos(d[79:64], c, s);
    a = (c * x + s * z + 32768) >>> 16;
    b = (c * z - s * x + 32768) >>> 16;
    x = a;
    z = b;
    angle_sincos(d[95:80], c, s);
    a = (c * x - s * y + 32768) >>> 16;
    b = (s * x + c * y + 32768) >>> 16;
    r.x = sat16(a);
    r.y = sat16(b);
    r.z = sat16(z);
    return r;
  endfunction

  assign pending = rotated_q.size();

  // Predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    point_t want, got;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        rotated_q.push_back(rotate_point(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        got.z = m_axis_tdata[47:32];
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = rotated_q.pop_front();
          if (want.x !== got.x)
            $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
          if (want.y !== got.y)
            $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
          if (want.z !== got.z)
            $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
          if (want !== got) errors <= errors + 1;
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Euler XYZ point rotation core: directed corner
// points and angles, then random points under random idling on both sides,
// with one long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1880;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Fields from bit 0: in_x, in_y, in_z, angle_x, angle_y, angle_z.
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Fields from bit 0: out_x, out_y, out_z.
  logic [47:0] m_axis_tdata;
  int          errors, pending, results_seen;
  int          cycles;
  bit          hold_done;
  int          points_sent;

  euler_xyz_point_rotation_core u_top (.*);

  erot_checker u_chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors, .pending, .results_seen
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle counter and timeout.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Idle for the gap, then present one point and wait until the core takes it.
  // Valid stays high after acceptance so that a point with no gap follows at once.
  task automatic send_point(input logic [15:0] px, py, pz, ax, ay, az,
                            input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {az, ay, ax, pz, py, px};
    do @(posedge clk); while (!s_axis_tready);
    points_sent++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 1023)) - 512);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Output side: random stalls, one long hold-off early in the random phase.
  initial begin
    int wait_cycles;
    m_axis_tready = 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      if (!hold_done && points_sent > 60) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      wait_cycles = (points_sent > 400 && points_sent < 700) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [15:0] corners[6];
    int gap;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    points_sent = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero angles, axis quadrants, fold boundaries, extreme points.
    corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0100, 16'h0001};
    send_point(16'h0100, 16'h0200, 16'h0300, 0, 0, 0, 0);
    send_point(16'h0100, 16'h0000, 16'h0000, 0, 0, 16'd16384, 0);
    send_point(16'h0000, 16'h0100, 16'h0000, 16'd16384, 0, 0, 1);
    send_point(16'h0000, 16'h0000, 16'h0100, 0, 16'd16384, 0, 0);
    send_point(16'h0100, 16'h0100, 16'h0100, 16'd32768, 16'd32768, 16'd32768, 0);
    send_point(16'h0100, 16'h0100, 16'h0100, 16'd16383, 16'd49151, 16'd49152, 2);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'd8192, 16'd8192, 16'd8192, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'd8192, 16'd8192, 16'd8192, 0);
    send_point(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_point(16'h8000, 16'h7fff, 16'h8000, 16'd57344, 16'd24576, 16'd40960, 0);
    for (int i = 0; i < 6; i++)
      send_point(corners[i], corners[5 - i], corners[(i + 2) % 6],
                 16'(i * 10923), 16'(65535 - i * 7000), 16'(i * 21845), i % 2);

    // Random points with random gaps; a run of back-to-back traffic mid-way.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      gap = (n > 300 && n < 600) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      send_point(rand_coord(), rand_coord(), rand_coord(),
                 rand_angle(), rand_angle(), rand_angle(), gap);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d points (corners, quadrant edges, random), %0d results checked.",
             points_sent, results_seen);
    $display("Both sides idled at random, with one long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/erot_pkg.sv
rtl/erot_cordic.sv
rtl/erot_axis.sv
rtl/euler_xyz_point_rotation_core.sv
test/erot_checker.sv
test/tb_top.sv
